@@ rtl/core/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the Morse sample decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

    // result kinds
    localparam logic [1:0] KIND_LETTER = 2'd0;
    localparam logic [1:0] KIND_SPACE  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_UNIT_LEN  = 1'b1;

    localparam int SAMPLE_W = 12;
    localparam int UNIT_W   = 8;
    localparam int SYM_W    = 7;
    localparam int IDX_W    = 6;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd80;
    localparam logic [UNIT_W-1:0]   UNIT_LEN_RST  = 8'd3;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // binary Morse tree, dot = 2i+1, dash = 2i+2; zero marks an empty node.
    // the last entry is the saturated index and is always empty.
    localparam logic [SYM_W-1:0] MORSE_TREE [64] = '{
        7'h00, 7'h45, 7'h54, 7'h49, 7'h41, 7'h4E, 7'h4D, 7'h53,
        7'h55, 7'h52, 7'h57, 7'h44, 7'h4B, 7'h47, 7'h4F, 7'h48,
        7'h56, 7'h46, 7'h00, 7'h4C, 7'h00, 7'h50, 7'h4A, 7'h42,
        7'h58, 7'h43, 7'h59, 7'h5A, 7'h51, 7'h00, 7'h00, 7'h35,
        7'h34, 7'h00, 7'h33, 7'h00, 7'h00, 7'h00, 7'h32, 7'h00,
        7'h00, 7'h2B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h31, 7'h36,
        7'h3D, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h00, 7'h00, 7'h00, 7'h38, 7'h00, 7'h39, 7'h30, 7'h00
    };

    // one queue entry: the results caused by one sample (one or two)
    typedef struct packed {
        logic             two;
        logic [1:0]       kind0;
        logic [SYM_W-1:0] sym0;
        logic [1:0]       kind1;
        logic [SYM_W-1:0] sym1;
    } msd_entry_t;

endpackage

@@ rtl/core/msd_front.sv @@
// ----------------------------------------------------------------------------
// msd_front
// Config registers, level detection, run timing and tree walk; one sample per
// clock unless q_full; emits a queue entry when a sample causes results.
// ----------------------------------------------------------------------------
module msd_front #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [11:0]                   cfg_wdata,
    input  logic                          in_valid,
    input  logic [msd_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                          in_ready,
    input  logic                          q_full,
    output logic                          q_push,
    output msd_pkg::msd_entry_t           q_entry
);
    import msd_pkg::*;

    localparam int W = COUNTER_WIDTH + 1;
    localparam logic [1:0] LVL_OFF  = 2'd0;
    localparam logic [1:0] LVL_ON   = 2'd1;
    localparam logic [1:0] LVL_NONE = 2'd2;

    logic [SAMPLE_W-1:0]      threshold_reg;
    logic [UNIT_W-1:0]        unit_len_reg;
    logic                     in_msg_reg, in_msg_next;
    logic [1:0]               prev_reg, prev_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;

    logic                     accept, on, start, msg;
    logic [1:0]               p;
    logic [COUNTER_WIDTH-1:0] c, c_mid;
    logic [IDX_W-1:0]         ix;
    logic [W-1:0]             cw, u, u3, u7, u8p1;
    logic                     win_u, win_3, win_7;
    logic [IDX_W+1:0]         grow1, grow2;
    logic                     want_letter;
    logic [IDX_W-1:0]         letter_idx;
    logic [SYM_W-1:0]         letter_sym;
    logic                     letter_ok;
    logic                     sec_valid;
    logic [1:0]               sec_kind;
    logic [SYM_W-1:0]         sec_sym;

    // count in [center - dev, center + dev] without wrap
    function automatic logic in_win(input logic [W-1:0] cnt, input logic [W-1:0] center,
                                    input logic [W-1:0] dev);
        in_win = (cnt + dev >= center) && (cnt <= center + dev);
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign on       = in_sample > threshold_reg;
    assign start    = on && !in_msg_reg;
    assign msg      = in_msg_reg || on;
    assign p        = start ? LVL_NONE : prev_reg;
    assign c        = start ? '0 : cnt_reg;
    assign ix       = start ? '0 : idx_reg;

    assign cw   = W'(c);
    assign u    = W'(unit_len_reg);
    assign u3   = (u << 1) + u;
    assign u7   = (u << 3) - u;
    assign u8p1 = (u << 3) + W'(1);

    assign win_u = in_win(cw, u, W'(1));
    assign win_3 = in_win(cw, u3, W'(1));
    assign win_7 = in_win(cw, u7, W'(2));

    // one spare bit so that 2*63+2 does not wrap before saturation
    assign grow1 = {1'b0, ix, 1'b1};
    assign grow2 = {1'b0, ix, 1'b0} + (IDX_W+2)'(2);

    always_comb
    begin
        in_msg_next = in_msg_reg;
        prev_next   = prev_reg;
        c_mid       = c;
        idx_next    = ix;
        want_letter = 1'b0;
        letter_idx  = ix;
        sec_valid   = 1'b0;
        sec_kind    = KIND_LETTER;
        sec_sym     = '0;
        if (msg)
        begin
            in_msg_next = 1'b1;
            if (on)
            begin
                if (p == LVL_OFF)
                begin
                    if (c != '0 && win_3)
                    begin
                        want_letter = 1'b1;
                        idx_next    = '0;
                    end
                    else if (c != '0 && win_7)
                    begin
                        want_letter = 1'b1;
                        sec_valid   = 1'b1;
                        sec_kind    = KIND_SPACE;
                        sec_sym     = SPACE_CHAR[SYM_W-1:0];
                        idx_next    = '0;
                    end
                    c_mid = '0;
                end
                prev_next = LVL_ON;
            end
            else
            begin
                if (p == LVL_ON)
                begin
                    // a just-finished mark resets the count, so no end check
                    if (win_u)
                        idx_next = grow1 > 8'd63 ? 6'd63 : grow1[IDX_W-1:0];
                    else if (win_3)
                        idx_next = grow2 > 8'd63 ? 6'd63 : grow2[IDX_W-1:0];
                    c_mid = '0;
                end
                else if (cw > u8p1)
                begin
                    want_letter = 1'b1;
                    sec_valid   = 1'b1;
                    sec_kind    = KIND_END;
                    sec_sym     = '0;
                    in_msg_next = 1'b0;
                end
                prev_next = LVL_OFF;
            end
        end
        cnt_next = (msg && c_mid != '1) ? c_mid + COUNTER_WIDTH'(1) : c_mid;
    end

    assign letter_sym = MORSE_TREE[letter_idx];
    assign letter_ok  = want_letter && (letter_sym != '0);

    always_comb
    begin
        q_entry = '0;
        if (letter_ok)
        begin
            q_entry.kind0 = KIND_LETTER;
            q_entry.sym0  = letter_sym;
            q_entry.two   = sec_valid;
            q_entry.kind1 = sec_kind;
            q_entry.sym1  = sec_sym;
        end
        else
        begin
            q_entry.kind0 = sec_kind;
            q_entry.sym0  = sec_sym;
        end
    end

    assign q_push = accept && (letter_ok || sec_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            unit_len_reg  <= UNIT_LEN_RST;
            in_msg_reg    <= 1'b0;
            prev_reg      <= LVL_NONE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                    CFG_UNIT_LEN:  unit_len_reg  <= cfg_wdata[UNIT_W-1:0];
                    default:       ;
                endcase
            end
            if (accept)
            begin
                in_msg_reg <= in_msg_next;
                prev_reg   <= prev_next;
                cnt_reg    <= cnt_next;
                idx_reg    <= idx_next;
            end
        end
    end

endmodule

@@ rtl/core/msd_queue.sv @@
// ----------------------------------------------------------------------------
// msd_queue
// Short FIFO of result entries between front and back.
// ----------------------------------------------------------------------------
module msd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  msd_pkg::msd_entry_t push_entry,
    output logic                full,
    output logic                head_valid,
    output msd_pkg::msd_entry_t head_entry,
    input  logic                pop
);
    import msd_pkg::*;

    msd_entry_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = count_reg == (QPTR_W+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

@@ rtl/core/msd_back.sv @@
// ----------------------------------------------------------------------------
// msd_back
// Unpacks queue entries into single results behind an output register.
// ----------------------------------------------------------------------------
module msd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  msd_pkg::msd_entry_t        head_entry,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 out_kind,
    output logic [msd_pkg::SYM_W-1:0]  out_sym,
    output logic                       out_last
);
    import msd_pkg::*;

    logic             valid_reg;
    logic [1:0]       kind_reg;
    logic [SYM_W-1:0] sym_reg;
    logic             last_reg;
    logic             pend_reg;
    logic [1:0]       pend_kind_reg;
    logic [SYM_W-1:0] pend_sym_reg;
    logic             slot_free;

    assign slot_free = !valid_reg || out_ready;
    assign pop       = slot_free && !pend_reg && head_valid;

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_sym   = sym_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (slot_free)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= head_valid;
                pend_reg  <= head_valid && head_entry.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (pend_reg)
            begin
                kind_reg <= pend_kind_reg;
                sym_reg  <= pend_sym_reg;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg      <= head_entry.kind0;
                sym_reg       <= head_entry.sym0;
                last_reg      <= !head_entry.two;
                pend_kind_reg <= head_entry.kind1;
                pend_sym_reg  <= head_entry.sym1;
            end
        end
    end

endmodule

@@ rtl/core/morse_sample_decoder.sv @@
// ----------------------------------------------------------------------------
// morse_sample_decoder
// Decodes Morse code from a stream of raw converter samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock. A sample above the threshold register is a
// mark; the first mark starts a message. Mark runs of about one unit add a
// dot, about three units a dash; gaps of about three units close a letter,
// about seven close a letter and add a word space, and a gap longer than
// 8 units + 1 closes the message (pending letter, then an end result). Each
// letter is looked up in the Morse tree and only sent if the node is used.
// Results leave with the kind on m_tuser and the character on m_tdata.
// Rate: s_tready stays high and a sample is taken every clock as long as the
// 4-entry result queue has room. The output side drains one result per clock
// while m_tready is high; a sample that causes two results (letter + space or
// letter + end) holds the output register for both, so the queue fills only
// when results come faster than m_tready takes them. A result is presented
// after its sample passes the queue write and then the output register.
// Config writes take effect on the next clock and are meant for idle times.
// ----------------------------------------------------------------------------
module morse_sample_decoder #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: index 0 threshold, index 1 unit_len
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample
    // decoded results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] symbol
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import msd_pkg::*;

    logic             q_push, q_full, q_head_valid, q_pop;
    msd_entry_t       q_in, q_head;
    logic [1:0]       out_kind;
    logic [SYM_W-1:0] out_sym;

    // front: state update and classification
    msd_front #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // decouples sample intake from result delivery
    msd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    // back: one result per transaction
    msd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_sym    (out_sym),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_sym};
    assign m_tuser = out_kind;

    // an end-of-message result always closes its sample's results
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_END) |-> m_tlast)
        else $error("end result without tlast");

    // a word space always closes its sample's results
    a_space_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_SPACE) |-> m_tlast)
        else $error("space result without tlast");

    // only a letter can be followed by a second result
    a_first_is_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == KIND_LETTER))
        else $error("non-letter result not last");

    // after a first result is taken, the second one follows at once
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("second result missing");

endmodule

@@ tb/sv/morse_sample_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_sample_decoder_tb
// Self-checking bench for the Morse sample decoder.
// ----------------------------------------------------------------------------
// Samples go in as stream transactions and every one the block takes is run
// through a local decoder model, which queues the letters, word spaces and
// end-of-message results it must cause. Each result transaction is checked
// field by field against the head of that queue. Named tests cover the reset
// settings, the timing windows, odd run lengths, tree overflow, unit_len of
// zero, register extremes and back-pressure, followed by random Morse
// traffic under three idle mixes on both sides.
// ----------------------------------------------------------------------------
module morse_sample_decoder_tb;

    import msd_pkg::*;

    // quiet cycles allowed: the longest is the receiver hold of HOLD_CYCLES plus
    // random stalls around it, so this leaves a wide margin
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int CNT_MAX        = 65535;     // run counter all-ones, 16 bits
    localparam int HOLD_CYCLES    = 400;

    // Morse tree, node i at character i, '*' for an empty node
    localparam logic [8*63-1:0] MORSE_NODES =
        "*ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2**+****16=/*****7***8*90";

    typedef enum logic [1:0] {LVL_OFF = 2'd0, LVL_ON = 2'd1, LVL_NONE = 2'd2} level_t;

    // one decoded result, as it should leave the block
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] sym;
        logic       last;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [11:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [11:0] sample
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [6:0] symbol
    logic [1:0]  m_tuser;     // [1:0] kind
    logic        m_tlast;

    // decoder model state and its copy of the registers
    int       thr_q;
    int       unit_q;
    bit       in_msg;
    level_t   prev_lvl;
    int       run_cnt;
    int       tree_idx;

    decoded_t decoded_q[$];   // results still owed by the block
    decoded_t head_res;
    int       samples_sent;
    int       bad_results;
    int       quiet_cycles;

    // idle mix of both sides, in percent of cycles
    int       src_gap_pct;
    int       snk_gap_pct;

    // long receiver hold: the test toggles stall_req, the receiver counts it
    bit       stall_req;
    bit       stall_seen;
    int       stall_left;

    morse_sample_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    function automatic logic [6:0] tree_char(input int idx);
        logic [7:0] c;
        if (idx >= 63)
            return 7'd0;
        c = MORSE_NODES[8*(62-idx) +: 8];
        return (c == "*") ? 7'd0 : c[6:0];
    endfunction

    // count within center +- dev, no wrap below zero
    function automatic bit near(input int cnt, input int center, input int dev);
        return (cnt + dev >= center) && (cnt <= center + dev);
    endfunction

    function automatic int deeper(input int add);
        return (tree_idx * 2 + add > 63) ? 63 : tree_idx * 2 + add;
    endfunction

    function automatic void clear_model();
        thr_q    = THRESHOLD_RST;
        unit_q   = UNIT_LEN_RST;
        in_msg   = 1'b0;
        prev_lvl = LVL_NONE;
        run_cnt  = 0;
        tree_idx = 0;
    endfunction

    // one accepted sample: update the model, queue what it must produce
    function automatic void decode_sample(input logic [11:0] smp);
        decoded_t   outs[$];
        decoded_t   r;
        logic [6:0] ch;
        bit         mark;
        int         u;
        mark = (int'(smp) > thr_q);
        u    = unit_q;
        ch   = tree_char(tree_idx);
        if (mark && !in_msg)
        begin
            in_msg   = 1'b1;
            run_cnt  = 0;
            prev_lvl = LVL_NONE;
            tree_idx = 0;
        end
        if (in_msg)
        begin
            if (mark)
            begin
                // rising edge: the off run just ended closes a letter or a word
                if (prev_lvl == LVL_OFF)
                begin
                    if (run_cnt > 0 && near(run_cnt, 3 * u, 1))
                    begin
                        if (ch != 7'd0)
                            outs.push_back({KIND_LETTER, ch, 1'b0});
                        tree_idx = 0;
                    end
                    else if (run_cnt > 0 && near(run_cnt, 7 * u, 2))
                    begin
                        if (ch != 7'd0)
                            outs.push_back({KIND_LETTER, ch, 1'b0});
                        outs.push_back({KIND_SPACE, SPACE_CHAR[6:0], 1'b0});
                        tree_idx = 0;
                    end
                    run_cnt = 0;
                end
                prev_lvl = LVL_ON;
            end
            else
            begin
                // falling edge: dot window checked ahead of the dash window
                if (prev_lvl == LVL_ON)
                begin
                    if (near(run_cnt, u, 1))
                        tree_idx = deeper(1);
                    else if (near(run_cnt, 3 * u, 1))
                        tree_idx = deeper(2);
                    run_cnt = 0;
                end
                ch = tree_char(tree_idx);
                if (run_cnt > 8 * u + 1)
                begin
                    if (ch != 7'd0)
                        outs.push_back({KIND_LETTER, ch, 1'b0});
                    outs.push_back({KIND_END, 7'd0, 1'b0});
                    in_msg = 1'b0;
                end
                prev_lvl = LVL_OFF;
            end
            if (run_cnt < CNT_MAX)
                run_cnt++;
        end
        foreach (outs[i])
        begin
            r      = outs[i];
            r.last = (i == outs.size() - 1);
            decoded_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker, watchdog and receiver
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                bad_results++;
                $display("%0t: result with none owed: kind=%0d symbol=%0d last=%0b",
                         $time, m_tuser, m_tdata[6:0], m_tlast);
            end
            else
            begin
                head_res = decoded_q.pop_front();
                if (m_tuser !== head_res.kind || m_tdata[6:0] !== head_res.sym ||
                    m_tlast !== head_res.last)
                begin
                    bad_results++;
                    $display({"%0t: expected kind=%0d symbol=%0d last=%0b, ",
                              "got kind=%0d symbol=%0d last=%0b"},
                             $time, head_res.kind, head_res.sym, head_res.last,
                             m_tuser, m_tdata[6:0], m_tlast);
                end
            end
        end
    end

    // ends the run if neither side moves a transaction for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL morse_sample_decoder");
            $finish;
        end
    end

    // receiver: random ready, or held low for a requested stretch
    initial
    begin
        m_tready   = 1'b0;
        stall_seen = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_req != stall_seen)
            begin
                stall_seen = stall_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99, 0) >= snk_gap_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // offer one sample, with random gaps ahead of it; returns once taken
    task automatic send_sample(input logic [11:0] smp);
        @(negedge clk);
        while ($urandom_range(99, 0) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_sample(smp);
        samples_sent++;
    endtask

    // random mark or space sample, boundaries and rails now and then
    function automatic logic [11:0] level_sample(input bit mark);
        int r;
        r = $urandom_range(9, 0);
        if (mark)
        begin
            if (r == 0)
                return 12'(thr_q + 1);
            if (r == 1)
                return 12'hFFF;
            return 12'($urandom_range(4095, thr_q + 1));
        end
        if (r == 0)
            return 12'(thr_q);
        if (r == 1)
            return 12'h000;
        return 12'($urandom_range(thr_q, 0));
    endfunction

    task automatic send_run(input bit mark, input int len);
        repeat (len)
            send_sample(level_sample(mark));
    endtask

    // alternating runs, mark first
    task automatic send_pattern(input int lens[$]);
        foreach (lens[i])
            send_run(i % 2 == 0, lens[i]);
    endtask

    // drop valid, let every owed result out, then allow the pipe to settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [11:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == CFG_THRESHOLD)
            thr_q = val;
        else
            unit_q = val[7:0];
    endtask

    function automatic int jitter(input int center, input int dev);
        int v;
        v = center + $urandom_range(2 * dev, 0) - dev;
        return (v < 1) ? 1 : v;
    endfunction

    // one message: well formed with jittered timing, or random runs
    task automatic send_message(input bit noisy);
        int u;
        int letters;
        int syms;
        u = unit_q;
        send_run(1'b0, $urandom_range(3, 0));   // ignored idle samples
        if (noisy)
        begin
            repeat ($urandom_range(10, 1))
            begin
                send_run(1'b1, $urandom_range(8 * u + 2, 1));
                send_run(1'b0, $urandom_range(8 * u + 2, 1));
            end
        end
        else
        begin
            letters = $urandom_range(5, 1);
            for (int i = 0; i < letters; i++)
            begin
                // six symbols run the tree index into saturation
                syms = ($urandom_range(9, 0) == 0) ? 6 : $urandom_range(5, 1);
                for (int j = 0; j < syms; j++)
                begin
                    send_run(1'b1, jitter($urandom_range(1, 0) ? 3 * u : u, 1));
                    if (j < syms - 1)
                        send_run(1'b0, jitter(u, 1));
                end
                if (i < letters - 1)
                begin
                    if ($urandom_range(3, 0) == 0)
                        send_run(1'b0, jitter(7 * u, 2));
                    else
                        send_run(1'b0, jitter(3 * u, 1));
                end
            end
        end
        // silence long enough to close the message
        send_run(1'b0, 8 * u + 3 + $urandom_range(3, 0));
    endtask

    task automatic randomize_regs();
        int u;
        int r;
        r = $urandom_range(99, 0);
        if (r < 80)
            u = $urandom_range(4, 1);
        else if (r < 98)
            u = $urandom_range(12, 5);
        else
            u = $urandom_range(40, 13);
        write_reg(CFG_THRESHOLD, 12'($urandom_range(4000, 0)));
        // upper nibble is junk, only [7:0] is the unit length
        write_reg(CFG_UNIT_LEN, {4'($urandom), 8'(u)});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset settings, threshold boundary, then dot, dash, letter, word, end
    task automatic test_basic_timing();
        int pat[$];
        send_sample(12'd0);           // idle: ignored
        send_sample(12'd80);          // at threshold: still off
        send_sample(12'd81);
        send_sample(12'hFFF);
        send_sample(12'd81);          // three marks at unit 3: dot
        send_sample(12'd80);
        send_run(1'b0, 26);           // E, then end of message
        write_reg(CFG_UNIT_LEN, 12'd1);
        // at unit 1 the dot and dash windows overlap (dot wins on 2)
        pat = '{1, 3, 3, 7, 2, 1, 4, 4, 1, 11};
        send_pattern(pat);
    endtask

    // runs outside every window, tree overflow, empty tree node
    task automatic test_odd_runs();
        int pat[$];
        write_reg(CFG_THRESHOLD, 12'd2047);
        write_reg(CFG_UNIT_LEN, 12'd4);
        pat = '{7, 1, 12, 20, 4, 12,
                12, 4, 12, 4, 12, 4, 12, 4, 12, 4, 12, 4, 12, 12,
                4, 4, 4, 4, 12, 4, 12, 35};
        send_pattern(pat);
    endtask

    // unit_len of zero: all windows open from zero, end limit of one
    task automatic test_unit_zero();
        int pat[$];
        write_reg(CFG_THRESHOLD, 12'd80);
        write_reg(CFG_UNIT_LEN, 12'd0);
        pat = '{1, 1, 1, 2, 3, 1, 1, 3};
        send_pattern(pat);
    endtask

    // threshold rails, then a dot at the longest unit; the message stays open
    task automatic test_reg_extremes();
        write_reg(CFG_THRESHOLD, 12'hFFF);
        send_sample(12'hFFF);         // nothing can be a mark
        send_sample(12'h000);
        send_sample(12'h800);
        write_reg(CFG_THRESHOLD, 12'h000);
        write_reg(CFG_UNIT_LEN, 12'd255);
        send_sample(12'h000);         // idle
        send_run(1'b1, 255);
        send_run(1'b0, 10);
    endtask

    // receiver holds off while letters pour in, then a full drain pause
    task automatic test_backpressure();
        write_reg(CFG_THRESHOLD, 12'd80);
        write_reg(CFG_UNIT_LEN, 12'd1);
        stall_req = ~stall_req;
        repeat (60)
        begin
            send_run(1'b1, 1);
            send_run(1'b0, 3);
        end
        send_run(1'b0, 8);
        wait_idle();                  // sender waits for every result
        repeat (10)
        begin
            send_run(1'b1, 3);
            send_run(1'b0, 7);
        end
        send_run(1'b0, 4);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int count);
        int goal;
        src_gap_pct = src_pct;
        snk_gap_pct = snk_pct;
        goal = samples_sent + count;
        while (samples_sent < goal)
        begin
            if ($urandom_range(2, 0) == 0)
                randomize_regs();
            send_message($urandom_range(99, 0) < 20);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_THRESHOLD;
        cfg_wdata    = 12'd0;
        s_tvalid     = 1'b0;
        s_tdata      = 16'd0;
        src_gap_pct  = 0;
        snk_gap_pct  = 0;
        stall_req    = 1'b0;
        samples_sent = 0;
        bad_results  = 0;
        quiet_cycles = 0;
        clear_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_timing();
        test_odd_runs();
        test_unit_zero();
        test_reg_extremes();
        test_backpressure();
        test_random_traffic(29, 70, 320);
        test_random_traffic(70, 29, 320);
        test_random_traffic(0, 0, 300);

        wait_idle();
        repeat (10) @(posedge clk);
        if (bad_results == 0)
            $display("PASS morse_sample_decoder");
        else
            $display("FAIL morse_sample_decoder");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/msd_pkg.sv
rtl/core/msd_front.sv
rtl/core/msd_queue.sv
rtl/core/msd_back.sv
rtl/core/morse_sample_decoder.sv
tb/sv/morse_sample_decoder_tb.sv
